### rtl/msr_pkg.sv
// ----------------------------------------------------------------------------
// msr_pkg
// Shared types and constants of the modular square root block.
// ----------------------------------------------------------------------------
package msr_pkg;

  // upper bound (exclusive) of the non-residue search
  localparam int unsigned ZLimit = 65536;
  localparam int ZLimitWidth = 17;

  // modular multiplier sequencer
  typedef enum logic [2:0] {
    MUL_IDLE = 3'b001,
    MUL_RUN  = 3'b010,
    MUL_DONE = 3'b100
  } mul_state_t;

  // main sequencer
  typedef enum logic [19:0] {
    ST_IDLE = 20'h00001,
    ST_RED  = 20'h00002,
    ST_RFIX = 20'h00004,
    ST_EUL  = 20'h00008,
    ST_QSH  = 20'h00010,
    ST_ZCHK = 20'h00020,
    ST_ZTST = 20'h00040,
    ST_CSET = 20'h00080,
    ST_TSET = 20'h00100,
    ST_RSET = 20'h00200,
    ST_LTOP = 20'h00400,
    ST_SQ   = 20'h00800,
    ST_CSQ  = 20'h01000,
    ST_UPC  = 20'h02000,
    ST_UPT  = 20'h04000,
    ST_UPR  = 20'h08000,
    ST_PWCK = 20'h10000,
    ST_PWR  = 20'h20000,
    ST_PWB  = 20'h40000,
    ST_OUT  = 20'h80000
  } state_t;

endpackage

### rtl/msr_if.sv
// ----------------------------------------------------------------------------
// msr_in_if / msr_out_if
// Valid/ready channels of the modular square root block.
// ----------------------------------------------------------------------------
interface msr_in_if #(parameter int MOD_WIDTH = 32);
  logic                        valid;
  logic                        ready;
  logic signed [MOD_WIDTH:0]   value;
  logic        [MOD_WIDTH-1:0] modulus;

  modport source (output valid, output value, output modulus, input ready);
  modport sink   (input valid, input value, input modulus, output ready);
endinterface

interface msr_out_if #(parameter int MOD_WIDTH = 32);
  logic                 valid;
  logic                 ready;
  logic [MOD_WIDTH-1:0] root;
  logic                 no_root;

  modport source (output valid, output root, output no_root, input ready);
  modport sink   (input valid, input root, input no_root, output ready);
endinterface

### rtl/msr_mulmod.sv
// ----------------------------------------------------------------------------
// msr_mulmod
// Bit-serial modular multiplier: (x*y) mod p, one bit of y per cycle.
// ----------------------------------------------------------------------------
module msr_mulmod #(
  parameter int MOD_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic [MOD_WIDTH-1:0] x,
  input  logic [MOD_WIDTH-1:0] y,
  input  logic [MOD_WIDTH-1:0] p,
  output logic                 done,
  output logic [MOD_WIDTH-1:0] prod
);
  import msr_pkg::*;

  localparam int W  = MOD_WIDTH;
  localparam int KW = $clog2(W + 1);

  mul_state_t   state_r, state_nxt;
  logic [W-1:0] x_r, x_nxt;
  logic [W-1:0] y_r, y_nxt;
  logic [W-1:0] acc_r, acc_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [W:0]   dbl, dsub, sum, ssub;

  always_comb begin
    dbl  = {acc_r, 1'b0};
    dsub = (dbl >= {1'b0, p}) ? dbl - {1'b0, p} : dbl;
    sum  = dsub + {1'b0, x_r};
    ssub = (sum >= {1'b0, p}) ? sum - {1'b0, p} : sum;
  end

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    acc_nxt   = acc_r;
    k_nxt     = k_r;
    case (state_r)
      MUL_IDLE: begin
        if (go) begin
          x_nxt     = x;
          y_nxt     = y;
          acc_nxt   = '0;
          k_nxt     = KW'(W);
          state_nxt = MUL_RUN;
        end
      end
      MUL_RUN: begin
        acc_nxt = y_r[W-1] ? ssub[W-1:0] : dsub[W-1:0];
        y_nxt   = {y_r[W-2:0], 1'b0};
        k_nxt   = k_r - 1'b1;
        if (k_r == KW'(1)) state_nxt = MUL_DONE;
      end
      MUL_DONE: state_nxt = MUL_IDLE;
      default:  state_nxt = MUL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MUL_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
    k_r   <= k_nxt;
  end

  assign done = (state_r == MUL_DONE);
  assign prod = acc_r;

endmodule

### rtl/modular_square_root.sv
// ----------------------------------------------------------------------------
// modular_square_root
// Tonelli-Shanks square root modulo a prime, built on one serial multiplier.
// ----------------------------------------------------------------------------
// Operation: the value is first reduced bit-serially modulo p, then the root is
//   found by a sequence of modular multiplications on the single serial
//   multiplier.
// Throughput: one transaction at a time; the input is not ready while busy.
// Reset: synchronous, active low; clears the sequencer and the output valid.
module modular_square_root #(
  parameter int MOD_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  msr_in_if.sink    in_ch,
  msr_out_if.source out_ch
);
  import msr_pkg::*;

  localparam int W  = MOD_WIDTH;
  localparam int CW = $clog2(W + 1);
  localparam int ZW = (W > ZLimitWidth) ? W : ZLimitWidth;

  state_t        state_r, state_nxt, ret_r, ret_nxt;
  logic [W:0]    mag_r, mag_nxt;
  logic          neg_r, neg_nxt;
  logic [W-1:0]  p_r, p_nxt;
  logic [W:0]    rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  a_r, a_nxt;
  logic [W-1:0]  acc_r, acc_nxt, base_r, base_nxt, exp_r, exp_nxt;
  logic [W-1:0]  q_r, q_nxt, z_r, z_nxt;
  logic [W-1:0]  c_r, c_nxt, t_r, t_nxt, r_r, r_nxt, b_r, b_nxt;
  logic [CW-1:0] m_r, m_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [W-1:0]  res_root_r, res_root_nxt;
  logic          res_nr_r, res_nr_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [W-1:0]  out_root_r, out_root_nxt;
  logic          out_nr_r, out_nr_nxt;

  logic          mul_go, mul_done;
  logic [W-1:0]  mul_x, mul_y, mul_prod;
  logic [W:0]    rsh, rsub, pp1;
  logic [W-1:0]  e_half, e_quarter, e_qhalf, one_w;
  logic [CW-1:0] mi_diff;

  msr_mulmod #(.MOD_WIDTH(W)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mul_go),
    .x     (mul_x),
    .y     (mul_y),
    .p     (p_r),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  always_comb begin
    one_w     = W'(1);
    rsh       = {rem_r[W-1:0], mag_r[cnt_r[CW-1:0]]};
    rsub      = (rsh >= {1'b0, p_r}) ? rsh - {1'b0, p_r} : rsh;
    pp1       = {1'b0, p_r} + 1'b1;
    e_half    = (p_r - one_w) >> 1;
    e_quarter = W'(pp1 >> 2);
    e_qhalf   = W'(({1'b0, q_r} + 1'b1) >> 1);
    mi_diff   = m_r - i_r;
  end

  // multiplier operand selection
  always_comb begin
    mul_go = 1'b0;
    mul_x  = b_r;
    mul_y  = b_r;
    case (state_r)
      ST_PWR: begin
        mul_go = 1'b1;
        mul_x  = acc_r;
        mul_y  = base_r;
      end
      ST_PWB: begin
        mul_go = 1'b1;
        mul_x  = base_r;
        mul_y  = base_r;
      end
      ST_SQ:  mul_go = (b_r != one_w);
      ST_CSQ: mul_go = ((j_r + 1'b1) < mi_diff);
      ST_UPC: mul_go = 1'b1;
      ST_UPT: begin
        mul_go = 1'b1;
        mul_x  = t_r;
        mul_y  = c_r;
      end
      ST_UPR: begin
        mul_go = 1'b1;
        mul_x  = r_r;
        mul_y  = b_r;
      end
      default: mul_go = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    p_nxt         = p_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    a_nxt         = a_r;
    acc_nxt       = acc_r;
    base_nxt      = base_r;
    exp_nxt       = exp_r;
    q_nxt         = q_r;
    z_nxt         = z_r;
    c_nxt         = c_r;
    t_nxt         = t_r;
    r_nxt         = r_r;
    b_nxt         = b_r;
    m_nxt         = m_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    res_root_nxt  = res_root_r;
    res_nr_nxt    = res_nr_r;
    out_valid_nxt = out_valid_r;
    out_root_nxt  = out_root_r;
    out_nr_nxt    = out_nr_r;

    if (out_ch.ready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          p_nxt   = in_ch.modulus;
          neg_nxt = in_ch.value[W];
          mag_nxt = in_ch.value[W] ? (W + 1)'(-in_ch.value) : in_ch.value;
          rem_nxt = '0;
          cnt_nxt = CW'(W);
          if (in_ch.modulus == '0) begin
            res_root_nxt = '0;
            res_nr_nxt   = 1'b1;
            state_nxt    = ST_OUT;
          end else if (in_ch.modulus == W'(2)) begin
            res_root_nxt = W'(in_ch.value[0]);
            res_nr_nxt   = 1'b0;
            state_nxt    = ST_OUT;
          end else begin
            state_nxt = ST_RED;
          end
        end
      end
      // restoring remainder, one bit of the magnitude a cycle
      ST_RED: begin
        rem_nxt = rsub;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = ST_RFIX;
      end
      ST_RFIX: begin
        a_nxt = (neg_r && rem_r != '0) ? p_r - rem_r[W-1:0] : rem_r[W-1:0];
        if (a_nxt == '0) begin
          res_root_nxt = '0;
          res_nr_nxt   = 1'b0;
          state_nxt    = ST_OUT;
        end else begin
          acc_nxt   = one_w;
          base_nxt  = a_nxt;
          exp_nxt   = e_half;
          ret_nxt   = ST_EUL;
          state_nxt = ST_PWCK;
        end
      end
      ST_EUL: begin
        if (acc_r != one_w) begin
          res_root_nxt = '0;
          res_nr_nxt   = 1'b1;
          state_nxt    = ST_OUT;
        end else if (p_r[1:0] == 2'b11) begin
          acc_nxt   = one_w;
          base_nxt  = a_r;
          exp_nxt   = e_quarter;
          ret_nxt   = ST_RSET;
          state_nxt = ST_PWCK;
          m_nxt     = '0;
          t_nxt     = one_w;
        end else begin
          q_nxt     = p_r - one_w;
          m_nxt     = '0;
          state_nxt = ST_QSH;
        end
      end
      // strip the factors of two from p-1
      ST_QSH: begin
        if (q_r != '0 && !q_r[0]) begin
          q_nxt = q_r >> 1;
          m_nxt = m_r + 1'b1;
        end else begin
          z_nxt     = W'(2);
          state_nxt = ST_ZCHK;
        end
      end
      ST_ZCHK: begin
        if (z_r < p_r && ZW'(z_r) < ZW'(ZLimit)) begin
          acc_nxt   = one_w;
          base_nxt  = z_r;
          exp_nxt   = e_half;
          ret_nxt   = ST_ZTST;
          state_nxt = ST_PWCK;
        end else begin
          res_root_nxt = '0;
          res_nr_nxt   = 1'b1;
          state_nxt    = ST_OUT;
        end
      end
      ST_ZTST: begin
        if (acc_r == p_r - one_w) begin
          acc_nxt   = one_w;
          base_nxt  = z_r;
          exp_nxt   = q_r;
          ret_nxt   = ST_CSET;
          state_nxt = ST_PWCK;
        end else begin
          z_nxt     = z_r + 1'b1;
          state_nxt = ST_ZCHK;
        end
      end
      ST_CSET: begin
        c_nxt     = acc_r;
        acc_nxt   = one_w;
        base_nxt  = a_r;
        exp_nxt   = q_r;
        ret_nxt   = ST_TSET;
        state_nxt = ST_PWCK;
      end
      ST_TSET: begin
        t_nxt     = acc_r;
        acc_nxt   = one_w;
        base_nxt  = a_r;
        exp_nxt   = e_qhalf;
        ret_nxt   = ST_RSET;
        state_nxt = ST_PWCK;
      end
      // for p mod 4 = 3, t was set to one so the loop exits at once
      ST_RSET: begin
        r_nxt     = acc_r;
        state_nxt = ST_LTOP;
      end
      ST_LTOP: begin
        if (t_r == one_w) begin
          res_root_nxt = r_r;
          res_nr_nxt   = 1'b0;
          state_nxt    = ST_OUT;
        end else begin
          i_nxt     = '0;
          b_nxt     = t_r;
          state_nxt = ST_SQ;
        end
      end
      // find the least i with t^(2^i) = 1
      ST_SQ: begin
        if (b_r == one_w) begin
          j_nxt     = '0;
          b_nxt     = c_r;
          state_nxt = ST_CSQ;
        end else if (mul_done) begin
          b_nxt = mul_prod;
          i_nxt = i_r + 1'b1;
          if (i_nxt >= m_r) begin
            res_root_nxt = '0;
            res_nr_nxt   = 1'b1;
            state_nxt    = ST_OUT;
          end
        end
      end
      ST_CSQ: begin
        if ((j_r + 1'b1) >= mi_diff) begin
          m_nxt     = i_r;
          state_nxt = ST_UPC;
        end else if (mul_done) begin
          b_nxt = mul_prod;
          j_nxt = j_r + 1'b1;
        end
      end
      ST_UPC: begin
        if (mul_done) begin
          c_nxt     = mul_prod;
          state_nxt = ST_UPT;
        end
      end
      ST_UPT: begin
        if (mul_done) begin
          t_nxt     = mul_prod;
          state_nxt = ST_UPR;
        end
      end
      ST_UPR: begin
        if (mul_done) begin
          r_nxt     = mul_prod;
          state_nxt = ST_LTOP;
        end
      end
      // square-and-multiply, exponent bits from the bottom
      ST_PWCK: begin
        if (exp_r == '0) state_nxt = ret_r;
        else if (exp_r[0]) state_nxt = ST_PWR;
        else state_nxt = ST_PWB;
      end
      ST_PWR: begin
        if (mul_done) begin
          acc_nxt   = mul_prod;
          state_nxt = ST_PWB;
        end
      end
      ST_PWB: begin
        if (mul_done) begin
          base_nxt  = mul_prod;
          exp_nxt   = exp_r >> 1;
          state_nxt = ST_PWCK;
        end
      end
      // hold the result until the output register is free
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_root_nxt  = res_root_r;
          out_nr_nxt    = res_nr_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ret_r      <= ret_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    p_r        <= p_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    a_r        <= a_nxt;
    acc_r      <= acc_nxt;
    base_r     <= base_nxt;
    exp_r      <= exp_nxt;
    q_r        <= q_nxt;
    z_r        <= z_nxt;
    c_r        <= c_nxt;
    t_r        <= t_nxt;
    r_r        <= r_nxt;
    b_r        <= b_nxt;
    m_r        <= m_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    res_root_r <= res_root_nxt;
    res_nr_r   <= res_nr_nxt;
    out_root_r <= out_root_nxt;
    out_nr_r   <= out_nr_nxt;
  end

  assign in_ch.ready    = (state_r == ST_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.root    = out_root_r;
  assign out_ch.no_root = out_nr_r;

endmodule
